FILE: design/f32rd_pkg.sv
// package: phase codes, result kinds, status codes and constants of the root file reader
`default_nettype none
package f32rd_pkg;

  localparam int unsigned SectorWords = 128;
  localparam int unsigned WordIdxW    = $clog2(SectorWords);

  localparam logic [27:0] ClusterMask = 28'hFFF_FFFF;
  localparam logic [27:0] ChainEnd    = 28'hFFF_FFF8;
  localparam logic [7:0]  DeletedMark = 8'hE5;
  localparam logic [7:0]  LfnAttr     = 8'h0F;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DIR     = 3'd1,
    PH_DRAIN   = 3'd2,
    PH_DIRFAT  = 3'd3,
    PH_DATA    = 3'd4,
    PH_DATAFAT = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_WORD  = 2'd1,
    FN_FAIL  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KD_REQ  = 2'd0,
    KD_DATA = 2'd1,
    KD_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RDERR    = 2'd2,
    ST_BADREQ   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CR_PART  = 3'd0,
    CR_FAT   = 3'd1,
    CR_DATA  = 3'd2,
    CR_SPC   = 3'd3,
    CR_ROOT  = 3'd4,
    CR_MAX   = 3'd5,
    CR_HEAD  = 3'd6,
    CR_TAIL  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sector_lba;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [1:0]  status;
    logic [31:0] entry_size;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

FILE: design/fat32_root_file_reader_core.sv
// top level: FAT32 root directory search and cluster chain file reader
// results: the first result of a word is registered and shown the cycle after acceptance
// throughput: one input word per cycle while the output is not stalled; a word that causes two
// results holds off input until its second result, held in a one-entry skid register, moves to output
// input is taken while the skid register is empty and the output register is free
// reset: asynchronous active low; phase idle, counters zero, registers at defaults
`default_nettype none
module fat32_root_file_reader_core
  import f32rd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      sector_lba_o,
  output logic [31:0]      data_word_o,
  output logic [2:0]       byte_count_o,
  output logic [1:0]       status_o,
  output logic [31:0]      entry_size_o,
  output logic             last_of_run_o
);

  // configuration registers
  logic [31:0] part_q, data_start_q, max_q;
  logic [15:0] fat_q;
  logic [7:0]  spc_q;
  logic [27:0] root_q;
  logic [63:0] head_q;
  logic [23:0] tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0; fat_q <= 16'd32; data_start_q <= '0; spc_q <= 8'd8;
      root_q <= 28'd2; max_q <= '0; head_q <= '0; tail_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CR_PART: part_q       <= cfg_data_i[31:0];
        CR_FAT:  fat_q        <= cfg_data_i[15:0];
        CR_DATA: data_start_q <= cfg_data_i[31:0];
        CR_SPC:  spc_q        <= cfg_data_i[7:0];
        CR_ROOT: root_q       <= cfg_data_i[27:0];
        CR_MAX:  max_q        <= cfg_data_i[31:0];
        CR_HEAD: head_q       <= cfg_data_i;
        CR_TAIL: tail_q       <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // walk state
  phase_e              phase_q, phase_d;
  logic [WordIdxW-1:0] widx_q, widx_d;
  logic [7:0]          sic_q, sic_d;
  logic [27:0]         clus_q, clus_d;
  logic                cand_q, cand_d;
  logic [15:0]         hi_q, hi_d, lo_q, lo_d;
  logic [31:0]         left_q, left_d, fsize_q, fsize_d;

  // output stage and skid
  result_t out_q, skid_q, r0, r1;
  logic    out_v_q, skid_v_q;
  logic    n0, n1;
  logic    out_free;

  logic accept;
  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = !skid_v_q && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // first sector of a cluster; one 32-bit multiply of (cluster - 2) by sectors per cluster
  function automatic logic [31:0] clus_lba(input logic [27:0] c, input logic [31:0] p,
                                           input logic [31:0] ds, input logic [7:0] spc);
    logic [31:0] cm;
    cm = 32'({4'b0, c} - 32'd2) * 32'(spc);
    return p + ds + cm;
  endfunction

  function automatic result_t mk(input logic [1:0] k, input logic [31:0] lba,
                                 input logic [31:0] d, input logic [2:0] cnt,
                                 input logic [1:0] st, input logic [31:0] sz);
    result_t r;
    r.kind = k; r.sector_lba = lba; r.data_word = d; r.byte_count = cnt;
    r.status = st; r.entry_size = sz; r.last_of_run = 1'b0;
    return r;
  endfunction

  // per-input step: start, word and fail commands
  always_comb begin
    logic        last, fin;
    logic [2:0]  e;
    logic [31:0] rem, keep, cnt32, fat_lba, cur_lba;
    logic [27:0] c;
    logic [7:0]  sic_inc;
    result_t     a, b;
    logic        na, nb;
    phase_d = phase_q; widx_d = widx_q; sic_d = sic_q; clus_d = clus_q;
    cand_d = cand_q; hi_d = hi_q; lo_d = lo_q; left_d = left_q; fsize_d = fsize_q;
    a = '0; b = '0; na = 1'b0; nb = 1'b0; fin = 1'b0;
    last = (widx_q == WordIdxW'(SectorWords - 1));
    e = widx_q[2:0];
    rem = (word_i < max_q) ? word_i : max_q;
    c = {hi_q[11:0], lo_q};
    cnt32 = (left_q < 32'd4) ? left_q : 32'd4;
    keep = (cnt32 >= 32'd4) ? 32'hFFFF_FFFF : ((32'd1 << {cnt32[1:0], 3'b0}) - 32'd1);
    sic_inc = sic_q + 8'd1;
    fat_lba = part_q + 32'(fat_q) + 32'(clus_q[27:WordIdxW]);
    cur_lba = '0;
    case (func_e'(func_i))
      FN_START: begin
        fsize_d = '0;
        na = 1'b1;
        if (max_q == '0 || spc_q == '0) begin
          a = mk(KD_DONE, '0, '0, '0, ST_BADREQ, '0);
          phase_d = PH_IDLE;
        end else begin
          clus_d = root_q; sic_d = '0; widx_d = '0; cand_d = 1'b0; phase_d = PH_DIR;
          a = mk(KD_REQ, clus_lba(root_q, part_q, data_start_q, spc_q), '0, '0, ST_FOUND, '0);
        end
      end
      FN_FAIL: begin
        if (phase_q != PH_IDLE) begin
          na = 1'b1;
          phase_d = PH_IDLE;
          if (phase_q == PH_DIRFAT) a = mk(KD_DONE, '0, '0, '0, ST_NOTFOUND, '0);
          else if (phase_q == PH_DATAFAT) a = mk(KD_DONE, '0, '0, '0, ST_FOUND, fsize_q);
          else a = mk(KD_DONE, '0, '0, '0, ST_RDERR, '0);
        end
      end
      FN_WORD: begin
        if (phase_q != PH_IDLE) begin
          widx_d = last ? '0 : widx_q + 1'b1;
          // per-word work
          case (phase_q)
            PH_DIR: begin
              case (e)
                3'd0: begin
                  cand_d = 1'b0;
                  if (word_i[7:0] == 8'h00) begin
                    na = 1'b1; fin = 1'b1; phase_d = PH_IDLE;
                    a = mk(KD_DONE, '0, '0, '0, ST_NOTFOUND, '0);
                  end else if (word_i[7:0] == DeletedMark || word_i != head_q[31:0])
                    cand_d = 1'b1;
                end
                3'd1: if (word_i != head_q[63:32]) cand_d = 1'b1;
                3'd2: if (word_i[31:24] == LfnAttr || word_i[23:0] != tail_q) cand_d = 1'b1;
                3'd5: hi_d = word_i[15:0];
                3'd6: lo_d = word_i[31:16];
                3'd7: if (!cand_q) begin
                  fsize_d = word_i;
                  if (rem == '0 || c < 28'd2) begin
                    na = 1'b1; fin = 1'b1; phase_d = PH_IDLE;
                    a = mk(KD_DONE, '0, '0, '0, ST_FOUND, word_i);
                  end else begin
                    left_d = rem; clus_d = c; phase_d = PH_DRAIN;
                  end
                end
                default: ;
              endcase
            end
            PH_DIRFAT, PH_DATAFAT: begin
              if (!cand_q && widx_q == clus_q[WordIdxW-1:0]) begin
                clus_d = word_i[27:0] & ClusterMask; cand_d = 1'b1;
              end
            end
            PH_DATA: begin
              na = 1'b1;
              a = mk(KD_DATA, '0, word_i & keep, cnt32[2:0], ST_FOUND, '0);
              left_d = left_q - cnt32;
              if (left_q == cnt32) begin
                nb = 1'b1; fin = 1'b1; phase_d = PH_IDLE;
                b = mk(KD_DONE, '0, '0, '0, ST_FOUND, fsize_q);
              end
            end
            default: ;
          endcase
          // end of sector, taken from the phase after this word
          if (last && !fin) begin
            cur_lba = clus_lba(clus_d, part_q, data_start_q, spc_q);
            case (phase_d)
              PH_DIR, PH_DATA: begin
                nb = 1'b1; sic_d = sic_inc;
                if (sic_inc < spc_q) begin
                  b = mk(KD_REQ, cur_lba + 32'(sic_inc), '0, '0, ST_FOUND, '0);
                end else begin
                  phase_d = (phase_d == PH_DIR) ? PH_DIRFAT : PH_DATAFAT;
                  cand_d = 1'b0;
                  b = mk(KD_REQ, fat_lba, '0, '0, ST_FOUND, '0);
                end
              end
              PH_DRAIN: begin
                nb = 1'b1; sic_d = '0; phase_d = PH_DATA;
                b = mk(KD_REQ, cur_lba, '0, '0, ST_FOUND, '0);
              end
              PH_DIRFAT: begin
                nb = 1'b1;
                if (clus_d >= ChainEnd) begin
                  phase_d = PH_IDLE; b = mk(KD_DONE, '0, '0, '0, ST_NOTFOUND, '0);
                end else begin
                  sic_d = '0; cand_d = 1'b0; phase_d = PH_DIR;
                  b = mk(KD_REQ, cur_lba, '0, '0, ST_FOUND, '0);
                end
              end
              PH_DATAFAT: begin
                nb = 1'b1;
                if (clus_d >= ChainEnd || clus_d < 28'd2) begin
                  phase_d = PH_IDLE; b = mk(KD_DONE, '0, '0, '0, ST_FOUND, fsize_q);
                end else begin
                  sic_d = '0; phase_d = PH_DATA;
                  b = mk(KD_REQ, cur_lba, '0, '0, ST_FOUND, '0);
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    // pack results in order
    if (na) begin
      r0 = a; r1 = b; n0 = 1'b1; n1 = nb;
    end else begin
      r0 = b; r1 = '0; n0 = nb; n1 = 1'b0;
    end
    if (n1) r1.last_of_run = 1'b1;
    else    r0.last_of_run = 1'b1;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; widx_q <= '0; sic_q <= '0; clus_q <= '0; cand_q <= 1'b0;
      hi_q <= '0; lo_q <= '0; left_q <= '0; fsize_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d; widx_q <= widx_d; sic_q <= sic_d; clus_q <= clus_d;
      cand_q <= cand_d; hi_q <= hi_d; lo_q <= lo_d; left_q <= left_d; fsize_q <= fsize_d;
    end
  end

  // output register and skid: input is taken only with skid empty and output free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q <= 1'b1; skid_v_q <= 1'b0;
      end else begin
        out_v_q <= accept && n0;
        skid_v_q <= accept && n1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) out_q <= skid_q;
      else begin
        out_q <= r0; skid_q <= r1;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign sector_lba_o  = out_q.sector_lba;
  assign data_word_o   = out_q.data_word;
  assign byte_count_o  = out_q.byte_count;
  assign status_o      = out_q.status;
  assign entry_size_o  = out_q.entry_size;
  assign last_of_run_o = out_q.last_of_run;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with output empty");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !in_ready_o) else $error("input taken with skid full");
  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FN_START && max_q != '0 && spc_q != '0) |=> widx_q == '0)
    else $error("word index not cleared on start");

endmodule
`default_nettype wire
